@@ rtl/ssqm_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-server queue monitor package
// Shared widths, record types and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package ssqm_pkg;

  localparam int QUEUE_DEPTH = 16;  // cells in the waiting line
  localparam int OCC_W  = 5;   // line length and capacity width
  localparam int SVC_W  = 2;   // service time width
  localparam int TICK_W = 32;  // tick counter width
  localparam int WAIT_W = 16;  // reported wait width
  localparam int CNT_W  = 32;  // customer count width
  localparam int SUM_W  = 48;  // running sum width

  localparam logic [OCC_W-1:0]  CAP_RESET = OCC_W'(16);
  localparam logic [WAIT_W-1:0] WAIT_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;

  // One waiting customer as held in a queue cell.
  typedef struct packed {
    logic [TICK_W-1:0] arrival_tick;
    logic [SVC_W-1:0]  service_time;
  } slot_t;

  // Control broadcast to every queue cell.
  typedef struct packed {
    logic             shift;   // head leaves, every cell takes its upper neighbour
    logic             load;    // an arrival is stored this cycle
    logic [OCC_W-1:0] wr_pos;  // cell that stores the arrival
  } cell_ctrl_t;

  // What happened in one tick, fed to the running totals.
  typedef struct packed {
    logic              joined;
    logic              turned_away;
    logic              started;
    logic [TICK_W-1:0] wait_ticks;
    logic [OCC_W-1:0]  line_length;
  } tick_event_t;

  // Running totals after the latest tick.
  typedef struct packed {
    logic [CNT_W-1:0] accepted;
    logic [CNT_W-1:0] served;
    logic [CNT_W-1:0] turned_away;
    logic [SUM_W-1:0] line_sum;
    logic [SUM_W-1:0] wait_sum;
  } totals_t;

  // Increment that sticks at the all-ones value.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // Add a 32-bit value to a 48-bit sum, sticking at the all-ones value.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [TICK_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/ssqm_cell.sv @@
// ----------------------------------------------------------------------------
// Queue cell
// One place of the shifting waiting line. On a departure it takes the
// contents of its upper neighbour; when addressed it stores a new arrival.
// ----------------------------------------------------------------------------
module ssqm_cell
  import ssqm_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  slot_t      arrival_slot,
  input  slot_t      upper_slot,
  output slot_t      slot
);

  logic  hit;
  slot_t slot_next;

  // Address decode for the storing cell.
  assign hit = ctrl.load && (int'(ctrl.wr_pos) == INDEX);

  // A store takes priority; otherwise the line moves up on a departure.
  always_comb begin
    priority if (hit) begin
      slot_next = arrival_slot;
    end else if (ctrl.shift) begin
      slot_next = upper_slot;
    end else begin
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

@@ rtl/ssqm_totals.sv @@
// ----------------------------------------------------------------------------
// Running totals
// Saturating counts of accepted, served and turned-away customers, and
// saturating sums of end-of-tick line length and of waits.
// ----------------------------------------------------------------------------
module ssqm_totals
  import ssqm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  tick_event_t ev,
  output totals_t     totals
);

  totals_t totals_next;

  // Update each total from this tick's events.
  always_comb begin
    totals_next = totals;
    if (ev.joined) begin
      totals_next.accepted = sat_inc(totals.accepted);
    end
    if (ev.turned_away) begin
      totals_next.turned_away = sat_inc(totals.turned_away);
    end
    if (ev.started) begin
      totals_next.served   = sat_inc(totals.served);
      totals_next.wait_sum = sat_add(totals.wait_sum, ev.wait_ticks);
    end
    totals_next.line_sum = sat_add(totals.line_sum, TICK_W'(ev.line_length));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else if (en) begin
      totals <= totals_next;
    end
  end

endmodule

@@ rtl/single_server_queue_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// Single-server queue monitor
// One tick per input transfer: arrivals join a shifting line of cells or are
// turned away, the free server takes the head, and running totals are kept.
//
//  channel   direction  handshake              payload
//  s_axis    in         s_tvalid / s_tready    s_tdata: arrival, service_time
//  m_axis    out        m_tvalid / m_tready    m_tdata: one result per tick
//  cfg       in         cfg_wr_en              cfg_wr_data: queue_capacity
//
// Each tick is worked out in the cycle of its input transfer and its result
// is presented on the next cycle; a new tick is taken every cycle unless the output stalls.
// The output register sets the rate: input is taken whenever that register
// is empty or its result is transferred in the same cycle.
// A stalled output holds its result and blocks input until it is taken.
// Reset is synchronous and empties the line and all totals; capacity
// returns to 16.
// ----------------------------------------------------------------------------
module single_server_queue_monitor_unit
  import ssqm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // fields from bit 0: arrival[0], service_time[2:1], zero fill
  input  logic [7:0]       s_tdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  // fields from bit 0: joined, turned_away, service_started, waited_ticks[16],
  // line_length[5], service_left[2], total_accepted[32], total_served[32],
  // total_turned_away[32], sum_line_length[48], sum_wait[48], zero fill
  output logic [223:0]     m_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  logic             cfg_wr_en,
  input  logic [OCC_W-1:0] cfg_wr_data
);

  logic              accept;
  logic              arrival;
  logic [SVC_W-1:0]  service_time;
  logic [OCC_W-1:0]  queue_capacity;
  logic [OCC_W-1:0]  cap;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  occupancy_next;
  logic [SVC_W-1:0]  busy_left;
  logic [SVC_W-1:0]  busy_left_next;
  logic [TICK_W-1:0] tick_count;
  logic              joined;
  logic              turned;
  logic              pop;
  slot_t             arrival_slot;
  slot_t             head_slot;
  logic [TICK_W-1:0] wait_ticks;
  cell_ctrl_t        ctrl;
  tick_event_t       ev;
  totals_t           totals;
  slot_t             cells [QUEUE_DEPTH];

  logic              out_joined;
  logic              out_turned;
  logic              out_started;
  logic [WAIT_W-1:0] out_waited;

  assign arrival      = s_tdata[0];
  assign service_time = s_tdata[2:1];
  assign s_tready     = !m_tvalid || m_tready;
  assign accept       = s_tvalid && s_tready;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      queue_capacity <= cfg_wr_data;
    end
  end

  // Effective capacity is clipped to the number of cells.
  always_comb begin
    if (int'(queue_capacity) < QUEUE_DEPTH) begin
      cap = queue_capacity;
    end else begin
      cap = OCC_W'(QUEUE_DEPTH);
    end
  end

  // Admission, departure and server countdown for this tick.
  always_comb begin
    joined       = arrival && (occupancy < cap);
    turned       = arrival && !joined;
    pop          = (busy_left == '0) && ((occupancy != '0) || joined);
    arrival_slot = '{arrival_tick: tick_count, service_time: service_time};
    // An arrival into an empty line goes straight to the server.
    head_slot    = (occupancy == '0) ? arrival_slot : cells[0];
    wait_ticks   = tick_count - head_slot.arrival_tick;

    occupancy_next = occupancy + OCC_W'(joined) - OCC_W'(pop);

    if (pop) begin
      busy_left_next = (head_slot.service_time == '0) ? '0
                                                      : head_slot.service_time - SVC_W'(1);
    end else begin
      busy_left_next = (busy_left == '0) ? '0 : busy_left - SVC_W'(1);
    end

    ctrl.shift  = accept && pop;
    ctrl.load   = accept && joined && !(pop && (occupancy == '0));
    ctrl.wr_pos = pop ? occupancy - OCC_W'(1) : occupancy;

    ev.joined      = joined;
    ev.turned_away = turned;
    ev.started     = pop;
    ev.wait_ticks  = wait_ticks;
    ev.line_length = occupancy_next;
  end

  // Line state and tick counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy  <= '0;
      busy_left  <= '0;
      tick_count <= '0;
    end else if (accept) begin
      occupancy  <= occupancy_next;
      busy_left  <= busy_left_next;
      tick_count <= tick_count + TICK_W'(1);
    end
  end

  // Row of cells; the head sits in cell 0 and the top cell refills from itself.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ssqm_cell #(
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .arrival_slot (arrival_slot),
      .upper_slot   (cells[(i + 1 < QUEUE_DEPTH) ? i + 1 : i]),
      .slot         (cells[i])
    );
  end

  ssqm_totals u_totals (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .ev     (ev),
    .totals (totals)
  );

  // Output register for the per-tick flags; totals and line state are read
  // from their own registers, which only move when a result is loaded here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_joined  <= joined;
      out_turned  <= turned;
      out_started <= pop;
      if (!pop) begin
        out_waited <= '0;
      end else if (wait_ticks > TICK_W'(WAIT_MAX)) begin
        out_waited <= WAIT_MAX;
      end else begin
        out_waited <= wait_ticks[WAIT_W-1:0];
      end
    end
  end

  assign m_tdata = {6'b0,
                    totals.wait_sum,
                    totals.line_sum,
                    totals.turned_away,
                    totals.served,
                    totals.accepted,
                    busy_left,
                    occupancy,
                    out_waited,
                    out_started,
                    out_turned,
                    out_joined};

endmodule

@@ test/single_server_queue_monitor_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Single-server queue monitor testbench
// Sends one tick per input transfer and checks every result transfer against
// a local model of the line, the server and the running totals. A short table
// covers the fixed cases first, then random phases follow, each with its own
// capacity, arrival load and idling pattern.
// ----------------------------------------------------------------------------
module single_server_queue_monitor_unit_test
  import ssqm_pkg::*;
;

  localparam int LINE_DEPTH  = QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_TICKS = 80;

  // Result fields, declared from the top bit down so that the struct lines up
  // with the packing of m_tdata (joined sits in bit 0).
  typedef struct packed {
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  line_sum;
    logic [CNT_W-1:0]  rejected;
    logic [CNT_W-1:0]  served;
    logic [CNT_W-1:0]  accepted;
    logic [SVC_W-1:0]  left;
    logic [OCC_W-1:0]  line;
    logic [WAIT_W-1:0] waited;
    logic              started;
    logic              turned_away;
    logic              joined;
  } tick_result_t;

  localparam int RESULT_W = $bits(tick_result_t);

  // One customer waiting in the line.
  typedef struct packed {
    logic [TICK_W-1:0] arrived;
    logic [SVC_W-1:0]  svc;
  } customer_t;

  typedef enum logic [0:0] {ROW_TICK, ROW_CAP} row_kind_t;

  // One row of the directed table; typed rows carry the short result fields.
  typedef struct packed {
    row_kind_t         kind;
    logic              arrival;
    logic [SVC_W-1:0]  svc;
    logic [OCC_W-1:0]  cap;
    logic              typed;
    logic              joined;
    logic              turned_away;
    logic              started;
    logic [WAIT_W-1:0] waited;
    logic [OCC_W-1:0]  line;
    logic [SVC_W-1:0]  left;
  } row_t;

  localparam int PLAN_ROWS = 24;

  logic               clk;
  logic               rst;
  logic [7:0]         s_tdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [223:0]       m_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic               cfg_wr_en;
  logic [OCC_W-1:0]   cfg_wr_data;

  // Local copy of the block's state.
  customer_t          waiting_line[$];
  logic [OCC_W-1:0]   line_cap;
  logic [SVC_W-1:0]   busy_ticks;
  logic [TICK_W-1:0]  tick_now;
  logic [CNT_W-1:0]   accepted_n;
  logic [CNT_W-1:0]   served_n;
  logic [CNT_W-1:0]   rejected_n;
  logic [SUM_W-1:0]   line_total;
  logic [SUM_W-1:0]   wait_total;

  tick_result_t       results_due[$];
  row_t               plan[PLAN_ROWS];
  int                 mismatches;
  int                 cycle_count;
  bit                 tx_calm;
  bit                 rx_calm;
  bit                 hold_req;

  single_server_queue_monitor_unit i_dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and stop a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                             input logic [SUM_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] grow(input logic [SUM_W-1:0] a,
                                            input logic [TICK_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Advance the local model by one tick and return the result it produces.
  function automatic tick_result_t advance_line(input logic arrival,
                                                input logic [SVC_W-1:0] svc);
    tick_result_t      res;
    customer_t         head;
    logic [TICK_W-1:0] waited;
    int                cap;
    res    = '0;
    waited = '0;
    cap    = (int'(line_cap) > LINE_DEPTH) ? LINE_DEPTH : int'(line_cap);

    // Arrival joins the line or is turned away when the line is full.
    if (arrival) begin
      if (waiting_line.size() >= cap) begin
        res.turned_away = 1'b1;
        rejected_n      = bump(rejected_n);
      end else begin
        res.joined = 1'b1;
        accepted_n = bump(accepted_n);
        waiting_line.push_back('{arrived: tick_now, svc: svc});
      end
    end

    // A free server takes the head of the line.
    if (busy_ticks == '0 && waiting_line.size() > 0) begin
      head        = waiting_line.pop_front();
      res.started = 1'b1;
      waited      = tick_now - head.arrived;
      busy_ticks  = head.svc;
      served_n    = bump(served_n);
      wait_total  = grow(wait_total, waited);
    end

    if (busy_ticks != '0)
      busy_ticks = busy_ticks - SVC_W'(1);

    line_total = grow(line_total, TICK_W'(waiting_line.size()));
    tick_now   = tick_now + TICK_W'(1);

    res.waited   = (waited > TICK_W'(WAIT_MAX)) ? WAIT_MAX : waited[WAIT_W-1:0];
    res.line     = OCC_W'(waiting_line.size());
    res.left     = busy_ticks;
    res.accepted = accepted_n;
    res.served   = served_n;
    res.rejected = rejected_n;
    res.line_sum = line_total;
    res.wait_sum = wait_total;
    return res;
  endfunction

  // Idle span: mostly a few cycles, now and then a long one.
  function automatic int idle_span();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // Offer one tick and record what it should produce once it is accepted.
  task automatic send_tick(input row_t r);
    tick_result_t due;
    int           gap;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : idle_span();
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, r.svc, r.arrival};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = advance_line(r.arrival, r.svc);
    if (r.typed) begin
      due.joined      = r.joined;
      due.turned_away = r.turned_away;
      due.started     = r.started;
      due.waited      = r.waited;
      due.line        = r.line;
      due.left        = r.left;
    end
    results_due.push_back(due);
  endtask

  // Write the capacity once every outstanding result has been transferred.
  task automatic set_capacity(input logic [OCC_W-1:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_cap  = v;
  endtask

  // Result side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = tick_result_t'(m_tdata[RESULT_W-1:0]);
      if (results_due.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = results_due.pop_front();
        check_field("joined", SUM_W'(got.joined), SUM_W'(want.joined));
        check_field("turned_away", SUM_W'(got.turned_away), SUM_W'(want.turned_away));
        check_field("service_started", SUM_W'(got.started), SUM_W'(want.started));
        check_field("waited_ticks", SUM_W'(got.waited), SUM_W'(want.waited));
        check_field("line_length", SUM_W'(got.line), SUM_W'(want.line));
        check_field("service_left", SUM_W'(got.left), SUM_W'(want.left));
        check_field("total_accepted", SUM_W'(got.accepted), SUM_W'(want.accepted));
        check_field("total_served", SUM_W'(got.served), SUM_W'(want.served));
        check_field("total_turned_away", SUM_W'(got.rejected), SUM_W'(want.rejected));
        check_field("sum_line_length", got.line_sum, want.line_sum);
        check_field("sum_wait", got.wait_sum, want.wait_sum);
      end
    end
  end

  // Receiver: random stalls, calm stretches and one long hold-off on request.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_calm || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        stall    = idle_span();
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed table, then random phases.
  initial begin
    row_t r;
    int   load;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    mismatches   = 0;
    cycle_count  = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_req     = 1'b0;
    line_cap     = CAP_RESET;
    busy_ticks   = '0;
    tick_now     = '0;
    accepted_n   = '0;
    served_n     = '0;
    rejected_n   = '0;
    line_total   = '0;
    wait_total   = '0;

    // kind, arrival, svc, cap, typed, joined, turned, started, waited, line, left
    plan = '{
      // Same-tick service into an empty line, then the countdown.
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 5'd0, 2'd2},
      '{ROW_TICK, 1'b0, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd1},
      // Zero service time joins while the server finishes.
      '{ROW_TICK, 1'b1, 2'd0, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 5'd1, 2'd0},
      '{ROW_TICK, 1'b0, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b1, 16'd1, 5'd0, 2'd0},
      // Service time without an arrival is ignored.
      '{ROW_TICK, 1'b0, 2'd3, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      // Capacity zero turns everyone away.
      '{ROW_CAP,  1'b0, 2'd0, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd1, 5'd0,  1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd2, 5'd0,  1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 5'd0, 2'd0},
      // Small capacity fills and turns the next arrival away.
      '{ROW_CAP,  1'b0, 2'd0, 5'd2,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      // Largest capacity value is clipped to the line depth.
      '{ROW_CAP,  1'b0, 2'd0, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd3, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      // Capacity lowered below the current line length.
      '{ROW_CAP,  1'b0, 2'd0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd1, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd1, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0},
      '{ROW_TICK, 1'b1, 2'd1, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 5'd0, 2'd0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAP)
        set_capacity(plan[i].cap);
      else
        send_tick(plan[i]);
    end

    // Random phases, each with its own capacity, load and idling.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_capacity(5'd16);
        1: set_capacity(5'd0);
        2: set_capacity(5'd31);
        3: set_capacity(5'd1);
        4: set_capacity(OCC_W'($urandom_range(2, 15)));
        6: set_capacity(OCC_W'($urandom_range(0, 31)));
        default: set_capacity(5'd16);
      endcase
      load    = $urandom_range(1, 4);
      tx_calm = (phase == 2) || ($urandom_range(0, 3) == 0);
      rx_calm = (phase != 2) && ($urandom_range(0, 3) == 0);
      // One phase holds the result side off while ticks keep coming.
      if (phase == 2) begin
        load     = 4;
        hold_req = 1'b1;
      end
      repeat (PHASE_TICKS) begin
        r         = '0;
        r.kind    = ROW_TICK;
        r.arrival = ($urandom_range(1, 4) <= load);
        r.svc     = SVC_W'($urandom_range(0, 3));
        send_tick(r);
      end
    end

    // Drain and finish.
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
